[design/pps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int ID_W    = 8;
  localparam int BURST_W = 8;
  localparam int PRIO_W  = 4;
  localparam int OUT_T_W = 16;

  localparam logic KIND_ADMIT = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_RESP,
    ST_TAT,
    ST_WAIT,
    ST_COMMIT
  } state_t;

endpackage : pps_pkg
`default_nettype wire

[design/pps_slot_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_slot_ram
// Job slot record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_slot_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 60,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : pps_slot_ram
`default_nettype wire

[design/preemptive_priority_scheduler_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Tick-driven preemptive priority scheduler over a table of job slots.
// ----------------------------------------------------------------------------
// An input word is either an admit (kind 0: job_id, burst_length, job_priority)
// or a clock tick (kind 1). Each accepted word yields exactly one result word.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// The block takes one word at a time. Each word first walks the slot table one
// slot per cycle through the record RAM read port, looking for the first free
// slot and the highest-priority valid job. A tick then fetches the chosen
// record and, if a job was found, runs three subtractions through one shared
// subtractor (ST_RESP, ST_TAT, ST_WAIT). Every word ends in ST_COMMIT, and the
// block returns to ST_IDLE before the next word is taken.
// A finished result sits in the output register; the next word can be taken
// while it waits, but the block holds before updating state until the output
// register is free. Reset clears the clock, all slot valid and started bits,
// and the output valid flag; the record RAM needs no clearing.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_core #(
  parameter int JOB_SLOTS = 8,
  parameter int TIME_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        kind,
  input  wire logic [pps_pkg::ID_W-1:0]    job_id,
  input  wire logic [pps_pkg::BURST_W-1:0] burst_length,
  input  wire logic [pps_pkg::PRIO_W-1:0]  job_priority,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             admit_rejected,
  output logic                             ran_valid,
  output logic [pps_pkg::ID_W-1:0]         ran_job,
  output logic                             job_done,
  output logic [pps_pkg::OUT_T_W-1:0]      turnaround,
  output logic [pps_pkg::OUT_T_W-1:0]      waiting,
  output logic [pps_pkg::OUT_T_W-1:0]      response
);

  localparam int IW        = $clog2(JOB_SLOTS);
  localparam int RESP_LSB  = 0;
  localparam int ARR_LSB   = TIME_BITS;
  localparam int REM_LSB   = 2 * TIME_BITS;
  localparam int BURST_LSB = REM_LSB + pps_pkg::BURST_W;
  localparam int PRIO_LSB  = BURST_LSB + pps_pkg::BURST_W;
  localparam int ID_LSB    = PRIO_LSB + pps_pkg::PRIO_W;
  localparam int REC_W     = ID_LSB + pps_pkg::ID_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(JOB_SLOTS - 1);

  pps_pkg::state_t state, state_next;

  // Captured input word.
  logic                        kind_q;
  logic [pps_pkg::ID_W-1:0]    id_q;
  logic [pps_pkg::BURST_W-1:0] burst_q;
  logic [pps_pkg::PRIO_W-1:0]  prio_q;

  logic [TIME_BITS-1:0] clock_now;
  logic [JOB_SLOTS-1:0] slot_valid;
  logic [JOB_SLOTS-1:0] slot_started;

  // Scan state.
  logic [IW-1:0]               scan_idx;
  logic                        cmp_en;
  logic [IW-1:0]               cmp_idx;
  logic                        pick_found;
  logic [IW-1:0]               pick_idx;
  logic [pps_pkg::PRIO_W-1:0]  pick_prio;
  logic                        free_found;
  logic [IW-1:0]               free_idx;

  // Shared subtractor and its results.
  logic [TIME_BITS-1:0] sub_a, sub_b, sub_y;
  logic [TIME_BITS-1:0] resp_q, tat_q, wait_q;

  // Record RAM port.
  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [REC_W-1:0] mem_wdata, mem_q;

  logic out_free, accept, commit;

  logic [pps_pkg::ID_W-1:0]    rec_id;
  logic [pps_pkg::PRIO_W-1:0]  rec_prio;
  logic [pps_pkg::BURST_W-1:0] rec_burst, rec_rem, rem_dec, burst_eff;
  logic [TIME_BITS-1:0]        rec_arr, rec_resp;
  logic                        run_done;

  assign rec_id    = mem_q[ID_LSB +: pps_pkg::ID_W];
  assign rec_prio  = mem_q[PRIO_LSB +: pps_pkg::PRIO_W];
  assign rec_burst = mem_q[BURST_LSB +: pps_pkg::BURST_W];
  assign rec_rem   = mem_q[REM_LSB +: pps_pkg::BURST_W];
  assign rec_arr   = mem_q[ARR_LSB +: TIME_BITS];
  assign rec_resp  = mem_q[RESP_LSB +: TIME_BITS];
  assign rem_dec   = rec_rem - pps_pkg::BURST_W'(1);
  assign run_done  = (rem_dec == '0);
  assign burst_eff = (burst_q == '0) ? pps_pkg::BURST_W'(1) : burst_q;

  assign sub_y    = sub_a - sub_b;
  assign in_stall = (state != pps_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  pps_slot_ram #(
    .DEPTH (JOB_SLOTS),
    .WIDTH (REC_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (accept) state_next = pps_pkg::ST_SCAN;
      end
      pps_pkg::ST_SCAN: begin
        if (scan_idx == LAST_SLOT) state_next = pps_pkg::ST_DRAIN;
      end
      pps_pkg::ST_DRAIN: begin
        state_next = (kind_q == pps_pkg::KIND_TICK) ? pps_pkg::ST_FETCH
                                                    : pps_pkg::ST_COMMIT;
      end
      pps_pkg::ST_FETCH: begin
        state_next = pick_found ? pps_pkg::ST_RESP : pps_pkg::ST_COMMIT;
      end
      pps_pkg::ST_RESP:   state_next = pps_pkg::ST_TAT;
      pps_pkg::ST_TAT:    state_next = pps_pkg::ST_WAIT;
      pps_pkg::ST_WAIT:   state_next = pps_pkg::ST_COMMIT;
      pps_pkg::ST_COMMIT: begin
        if (out_free) state_next = pps_pkg::ST_IDLE;
      end
      default: state_next = pps_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = scan_idx;
    mem_we    = 1'b0;
    mem_waddr = pick_idx;
    mem_wdata = {rec_id, rec_prio, rec_burst, rem_dec, rec_arr, resp_q};
    sub_a     = clock_now;
    sub_b     = rec_arr;
    commit    = 1'b0;
    unique case (state)
      pps_pkg::ST_SCAN: begin
        mem_re = 1'b1;
      end
      pps_pkg::ST_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = pick_idx;
      end
      pps_pkg::ST_TAT: begin
        sub_a = clock_now + TIME_BITS'(1);
      end
      pps_pkg::ST_WAIT: begin
        sub_a = tat_q;
        sub_b = TIME_BITS'(rec_burst);
      end
      pps_pkg::ST_COMMIT: begin
        commit = out_free;
        if (kind_q == pps_pkg::KIND_ADMIT) begin
          mem_we    = out_free && free_found;
          mem_waddr = free_idx;
          mem_wdata = {id_q, prio_q, burst_eff, burst_eff, clock_now, TIME_BITS'(0)};
        end else begin
          mem_we = out_free && pick_found;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= kind;
      id_q    <= job_id;
      burst_q <= burst_length;
      prio_q  <= job_priority;
    end
  end

  // Slot walk: a read issued in ST_SCAN is compared in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en     <= 1'b0;
      scan_idx   <= '0;
      pick_found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_en  <= (state == pps_pkg::ST_SCAN);
      cmp_idx <= scan_idx;
      if (accept) begin
        scan_idx   <= '0;
        pick_found <= 1'b0;
        free_found <= 1'b0;
      end else if (state == pps_pkg::ST_SCAN) begin
        scan_idx <= scan_idx + IW'(1);
      end
      if (cmp_en) begin
        if (slot_valid[cmp_idx]) begin
          // Strictly greater keeps the lowest slot on a tie.
          if (!pick_found || rec_prio > pick_prio) begin
            pick_found <= 1'b1;
            pick_idx   <= cmp_idx;
            pick_prio  <= rec_prio;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pps_pkg::ST_RESP) begin
      resp_q <= slot_started[pick_idx] ? rec_resp : sub_y;
    end
    if (state == pps_pkg::ST_TAT) begin
      tat_q <= sub_y;
    end
    if (state == pps_pkg::ST_WAIT) begin
      wait_q <= sub_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_now    <= '0;
      slot_valid   <= '0;
      slot_started <= '0;
    end else if (commit) begin
      if (kind_q == pps_pkg::KIND_ADMIT) begin
        if (free_found) begin
          slot_valid[free_idx]   <= 1'b1;
          slot_started[free_idx] <= 1'b0;
        end
      end else begin
        clock_now <= clock_now + TIME_BITS'(1);
        if (pick_found) begin
          slot_started[pick_idx] <= !run_done;
          if (run_done) slot_valid[pick_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      admit_rejected <= 1'b0;
      ran_valid      <= 1'b0;
      ran_job        <= '0;
      job_done       <= 1'b0;
      turnaround     <= '0;
      waiting        <= '0;
      response       <= '0;
      if (kind_q == pps_pkg::KIND_ADMIT) begin
        admit_rejected <= !free_found;
      end else if (pick_found) begin
        ran_valid <= 1'b1;
        ran_job   <= rec_id;
        if (run_done) begin
          job_done   <= 1'b1;
          turnaround <= pps_pkg::OUT_T_W'(tat_q);
          waiting    <= pps_pkg::OUT_T_W'(wait_q);
          response   <= pps_pkg::OUT_T_W'(resp_q);
        end
      end
    end
  end

endmodule : preemptive_priority_scheduler_core
`default_nettype wire
